### rtl/core/char_lcd_nibble_queue_driver_top_assert.svh
// Assertion macros for the LCD queue driver checker.
`ifndef CHAR_LCD_NIBBLE_QUEUE_DRIVER_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_QUEUE_DRIVER_TOP_ASSERT_SVH

// Plain property, clocked on clk, off during reset.
`define LCDQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define LCDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LCDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/lcdq_pkg.sv
// Types and constants for the character LCD nibble queue driver.
package lcdq_pkg;

	localparam int LINE_COUNT = 2;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_POS  = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CLEAR_CMD  = 8'h01;
	localparam logic [7:0] LINE1_BASE = 8'h80;
	localparam logic [7:0] LINE2_BASE = 8'hC0;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_WAIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_WAIT = 2'd1;

	localparam logic [7:0] SHORT_WAIT_RESET = 8'd2;
	localparam logic [7:0] CLEAR_WAIT_RESET = 8'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [5:0] column;
		logic [1:0] line_number;
	} item_t;

	typedef struct packed {
		logic       enable_pin;
		logic       select_pin;
		logic [3:0] data_nibble;
		logic [6:0] queue_level;
		logic       overflow_flag;
		logic [1:0] cursor_line;
	} result_t;

	// one queued nibble: long wait flag, register select, data
	typedef struct packed {
		logic       long_wait;
		logic       sel;
		logic [3:0] nibble;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic       push;
		entry_t     hi;
		entry_t     lo;
		logic [1:0] focus_next;
	} enc_t;

endpackage

### rtl/core/lcdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/lcdq_encode.sv
// Turns a character, command or cursor item into two nibble entries.
module lcdq_encode import lcdq_pkg::*; (
	input  item_t      item,
	input  logic [1:0] focus,
	output enc_t       enc
);

	logic [7:0] byte_v;
	logic       sel_v;
	logic       pos_v;
	logic [1:0] pos_line;
	logic [5:0] pos_col;

	always_comb begin
		byte_v   = '0;
		sel_v    = 1'b0;
		pos_v    = 1'b0;
		pos_line = focus;
		pos_col  = 6'd1;
		enc      = '0;
		enc.focus_next = focus;
		case (item.kind)
			KIND_CHAR: begin
				if (item.data_byte == CHAR_CR) begin
					pos_v = 1'b1;
				end else if (item.data_byte == CHAR_LF) begin
					pos_v    = 1'b1;
					pos_line = (focus >= 2'(LINE_COUNT)) ? 2'd1 : focus + 2'd1;
				end else begin
					enc.push = 1'b1;
					sel_v    = 1'b1;
					byte_v   = item.data_byte;
				end
			end
			KIND_CMD: begin
				enc.push = 1'b1;
				byte_v   = item.data_byte;
			end
			KIND_POS: begin
				pos_v    = 1'b1;
				pos_line = item.line_number;
				pos_col  = item.column;
			end
			default: begin
			end
		endcase

		if (pos_v) begin
			enc.push = 1'b1;
			if (pos_line == 2'd1) begin
				enc.focus_next = 2'd1;
				byte_v = LINE1_BASE + {2'b00, pos_col} - 8'd1;
			end else if (pos_line == 2'd2 && LINE_COUNT >= 2) begin
				enc.focus_next = 2'd2;
				byte_v = LINE2_BASE + {2'b00, pos_col} - 8'd1;
			end else begin
				// bad line falls back to home of line 1
				enc.focus_next = 2'd1;
				byte_v = LINE1_BASE;
			end
		end

		enc.hi.long_wait = 1'b0;
		enc.hi.sel       = sel_v;
		enc.hi.nibble    = byte_v[7:4];
		enc.lo.long_wait = (byte_v == CLEAR_CMD);
		enc.lo.sel       = sel_v;
		enc.lo.nibble    = byte_v[3:0];
	end

endmodule

### rtl/core/lcdq_fifo.sv
// Nibble queue: two interleaved RAM banks so a byte's two entries go in at once.
module lcdq_fifo import lcdq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  entry_t                     hi,
	input  entry_t                     lo,
	input  logic                       pop,
	output entry_t                     head,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic [$clog2(DEPTH+1)-1:0] count_next,
	output logic                       drop
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int HALF = (DEPTH + 1) / 2;
	localparam int AW   = $clog2(HALF);
	localparam logic [AW-1:0] LAST = AW'(HALF - 1);

	// entry n lives in bank n[0] at slot n/2, so neighbors sit in different banks
	logic          w_bank_q, r_bank_q;
	logic [AW-1:0] w_addr_q, r_addr_q;
	logic [CW-1:0] count_q;

	logic          ok1, ok2;
	logic [CW-1:0] count_one;
	logic [AW-1:0] w_addr_inc, r_addr_inc;

	logic          we0, we1;
	logic [AW-1:0] addr0;
	entry_t        data0, data1;
	logic [ENTRY_W-1:0] q0, q1;

	assign w_addr_inc = (w_addr_q == LAST) ? '0 : w_addr_q + 1'b1;
	assign r_addr_inc = (r_addr_q == LAST) ? '0 : r_addr_q + 1'b1;

	// each nibble checks for room on its own
	assign ok1       = push && (count_q < CW'(DEPTH));
	assign count_one = count_q + CW'(ok1);
	assign ok2       = push && (count_one < CW'(DEPTH));
	assign drop      = push && !ok2;

	assign we0   = w_bank_q ? ok2 : ok1;
	assign addr0 = w_bank_q ? w_addr_inc : w_addr_q;
	assign data0 = w_bank_q ? lo : hi;
	assign we1   = w_bank_q ? ok1 : ok2;
	assign data1 = w_bank_q ? hi : lo;

	lcdq_ram #(.WIDTH(ENTRY_W), .DEPTH(HALF)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (addr0),
		.wdata (data0),
		.raddr (r_addr_q),
		.rdata (q0)
	);

	lcdq_ram #(.WIDTH(ENTRY_W), .DEPTH(HALF)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (w_addr_q),
		.wdata (data1),
		.raddr (r_addr_q),
		.rdata (q1)
	);

	// read pointer only moves at a pop, and the head is not used until tick items step the drain machine to set
	assign head       = r_bank_q ? entry_t'(q1) : entry_t'(q0);
	assign count      = count_q;
	assign count_next = count_one + CW'(ok2) - CW'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_bank_q <= 1'b0;
			w_addr_q <= '0;
			r_bank_q <= 1'b0;
			r_addr_q <= '0;
			count_q  <= '0;
		end else begin
			count_q <= count_next;
			if (ok2) begin
				w_addr_q <= w_addr_inc;
			end else if (ok1) begin
				w_bank_q <= !w_bank_q;
				if (w_bank_q) begin
					w_addr_q <= w_addr_inc;
				end
			end
			if (pop) begin
				r_bank_q <= !r_bank_q;
				if (r_bank_q) begin
					r_addr_q <= r_addr_inc;
				end
			end
		end
	end

endmodule

### rtl/core/char_lcd_nibble_queue_driver_top.sv
// Top level of the character LCD nibble queue driver.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------
//  item     | item_valid / item_ready  | item (kind, byte, column, line)
//  result   | result_valid/result_ready| result (pins, level, flags)
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  One item per cycle sustained while results are taken; each item passes through the
//  input register, then is loaded into the result register once that register is free.
//  Reset clears pointers, count, drain phase, pins and flags; queue RAM is
//  left as is. No clearing pass.
//  A stalled result holds its register; one more item waits in the input
//  register, then item_ready drops. cfg_ready is always high.
module char_lcd_nibble_queue_driver_top import lcdq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_SET  = 2'd1;
	localparam logic [1:0] PH_BUSY = 2'd2;

	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;
	logic    adv, fire;

	logic [7:0] short_q, clear_q;
	logic [1:0] phase_q, phase_d;
	logic [7:0] elapsed_q, elapsed_d, elapsed_inc, wait_ticks;
	logic [1:0] focus_q;
	logic       dropped_q;
	logic       pin_en_q, pin_sel_q;
	logic [3:0] pin_nib_q;
	logic       pin_en_d, pin_sel_d;
	logic [3:0] pin_nib_d;
	logic       tick, pop;

	enc_t          enc;
	entry_t        head;
	logic [CW-1:0] count, count_next;
	logic          drop;

	assign adv        = !res_valid_q || result_ready;
	assign fire       = valid_s1 && adv;
	assign item_ready = !valid_s1 || adv;
	assign cfg_ready  = 1'b1;
	assign tick       = fire && (item_s1.kind == KIND_TICK);

	lcdq_encode u_enc (
		.item  (item_s1),
		.focus (focus_q),
		.enc   (enc)
	);

	lcdq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fire && enc.push),
		.hi         (enc.hi),
		.lo         (enc.lo),
		.pop        (pop),
		.head       (head),
		.count      (count),
		.count_next (count_next),
		.drop       (drop)
	);

	assign elapsed_inc = (elapsed_q == 8'hFF) ? elapsed_q : elapsed_q + 8'd1;
	assign wait_ticks  = head.long_wait ? clear_q : short_q;

	// drain machine, stepped by tick items only
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		pin_en_d  = pin_en_q;
		pin_sel_d = pin_sel_q;
		pin_nib_d = pin_nib_q;
		pop       = 1'b0;
		if (tick) begin
			case (phase_q)
				PH_SET: begin
					pin_en_d  = 1'b1;
					pin_sel_d = head.sel;
					pin_nib_d = head.nibble;
					elapsed_d = '0;
					phase_d   = PH_BUSY;
				end
				PH_BUSY: begin
					elapsed_d = elapsed_inc;
					// a zero wait still costs one busy tick
					if (elapsed_inc >= wait_ticks) begin
						pop     = (count != '0);
						phase_d = PH_WAIT;
					end
				end
				default: begin
					pin_en_d = 1'b0;
					phase_d  = (count != '0) ? PH_SET : PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			short_q     <= SHORT_WAIT_RESET;
			clear_q     <= CLEAR_WAIT_RESET;
			phase_q     <= PH_WAIT;
			elapsed_q   <= '0;
			focus_q     <= 2'd1;
			dropped_q   <= 1'b0;
			pin_en_q    <= 1'b0;
			pin_sel_q   <= 1'b0;
			pin_nib_q   <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SHORT_WAIT: short_q <= cfg_data;
					CFG_CLEAR_WAIT: clear_q <= cfg_data;
					default: begin
					end
				endcase
			end
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			pin_en_q  <= pin_en_d;
			pin_sel_q <= pin_sel_d;
			pin_nib_q <= pin_nib_d;
			dropped_q <= dropped_q | drop;
			if (fire) begin
				focus_q <= enc.focus_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (fire) begin
			res_q.enable_pin    <= pin_en_d;
			res_q.select_pin    <= pin_sel_d;
			res_q.data_nibble   <= pin_nib_d;
			res_q.queue_level   <= 7'(count_next);
			res_q.overflow_flag <= dropped_q | drop;
			res_q.cursor_line   <= enc.focus_next;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### rtl/core/lcdq_checker.sv
// Port-level checks for the LCD queue driver, bound to the top level.
`include "char_lcd_nibble_queue_driver_top_assert.svh"

module lcdq_checker import lcdq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input logic    clk,
	input logic    arst_n,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// reported level is seven bits wide
	localparam int LEVEL_CAP = (QUEUE_DEPTH > 127) ? 127 : QUEUE_DEPTH;

	logic ovf_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_seen_q <= 1'b0;
		end else if (result_valid && result_ready && result.overflow_flag) begin
			ovf_seen_q <= 1'b1;
		end
	end

	// overflow is sticky across result beats
	`LCDQ_ASSERT_IMPL(a_ovf_sticky, result_valid && ovf_seen_q, result.overflow_flag, "ovf cleared")

	`LCDQ_ASSERT_IMPL(a_level_max, result_valid, result.queue_level <= 7'(LEVEL_CAP), "level high")

	// input only backs up behind a stalled result
	`LCDQ_ASSERT_IMPL(a_ready_stall, !item_ready, result_valid && !result_ready, "bad stall")

	`LCDQ_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result),
		"stalled result changed")

endmodule

bind char_lcd_nibble_queue_driver_top lcdq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);
